@@ hw/rtl/sexpr_tokenizer_unit_macros.svh @@
// Assertion macros for the S-expression tokenizer.
`ifndef SEXPR_TOKENIZER_UNIT_MACROS_SVH
`define SEXPR_TOKENIZER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SXT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// next-cycle implication, disabled in reset
`define SXT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

@@ hw/rtl/sxt_pkg.sv @@
// Shared types and constants for the S-expression tokenizer.
package sxt_pkg;

	typedef enum logic [3:0] {
		KIND_END     = 4'd0,
		KIND_TAG     = 4'd1,
		KIND_SYMBOL  = 4'd2,
		KIND_INTEGER = 4'd3,
		KIND_STRING  = 4'd4,
		KIND_OPEN    = 4'd5,
		KIND_CLOSE   = 4'd6,
		KIND_QUOTE   = 4'd7,
		KIND_UNTERM  = 4'd8
	} sxt_kind_t;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_COMMENT = 5'b00010,
		MODE_STRING  = 5'b00100,
		MODE_TAG     = 5'b01000,
		MODE_WORD    = 5'b10000
	} sxt_mode_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} sxt_qstat_t;

	localparam int KIND_W      = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

endpackage

@@ hw/rtl/sxt_front.sv @@
// Front end: position tracking, scan mode and token classification per byte.
module sxt_front import sxt_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int LENGTH_BITS = 8,
	parameter int TOK_W       = KIND_W + 2 * LINE_BITS + LENGTH_BITS,
	parameter int PAIR_W      = 2 * TOK_W + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_in,
	output logic              wr_en,
	output logic [PAIR_W-1:0] wr_data
);

	sxt_mode_t              mode_q, mode_n;
	logic [LINE_BITS-1:0]   line_q, line_n, col_q, col_n;
	logic [LINE_BITS-1:0]   tl_q, tl_n, tc_q, tc_n;
	logic [LENGTH_BITS-1:0] len_q, len_n, len_inc;
	logic                   pre_q, pre_n, num_q, num_n, fd_q, fd_n;
	logic                   a_v, b_v, idle_pass;
	logic [TOK_W-1:0]       a_tok, b_tok;
	logic                   c_ws, c_dig, c_word;

	function automatic logic [TOK_W-1:0] mk_tok(input sxt_kind_t kind,
			input logic [LINE_BITS-1:0] ln, input logic [LINE_BITS-1:0] col,
			input logic [LENGTH_BITS-1:0] len);
		mk_tok = {kind, ln, col, len};
	endfunction

	assign c_ws   = (char_in == CH_SPACE) || (char_in >= CH_TAB && char_in <= CH_CR);
	assign c_dig  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign c_word = (char_in != CH_NUL) && (char_in != CH_LPAR) && (char_in != CH_RPAR) &&
		(char_in != CH_DQUOTE) && (char_in != CH_APOS) && !c_ws;
	assign len_inc = (len_q != '1) ? len_q + LENGTH_BITS'(1) : len_q;

	always_comb begin
		line_n = line_q;
		col_n  = col_q;
		pre_n  = pre_q;
		if (char_in == CH_LF) begin
			if (line_q != '1) line_n = line_q + LINE_BITS'(1);
			col_n = '0;
			pre_n = 1'b0;
		end else if (pre_q) begin
			col_n = '0;
			pre_n = 1'b0;
		end else if (col_q != '1) begin
			col_n = col_q + LINE_BITS'(1);
		end

		mode_n = mode_q;
		tl_n = tl_q;
		tc_n = tc_q;
		len_n = len_q;
		num_n = num_q;
		fd_n = fd_q;
		a_v = 1'b0;
		a_tok = '0;
		b_v = 1'b0;
		b_tok = '0;
		idle_pass = 1'b0;

		unique case (mode_q)
			MODE_COMMENT: begin
				if (char_in == CH_LF) begin
					mode_n = MODE_IDLE;
				end else if (char_in == CH_NUL) begin
					a_v = 1'b1;
					a_tok = mk_tok(KIND_UNTERM, tl_q, tc_q, '0);
					b_v = 1'b1;
					b_tok = mk_tok(KIND_END, line_n, col_n, '0);
					mode_n = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				if (char_in == CH_DQUOTE) begin
					len_n = len_inc;
					a_v = 1'b1;
					a_tok = mk_tok(KIND_STRING, tl_q, tc_q, len_inc);
					mode_n = MODE_IDLE;
				end else if (char_in == CH_NUL) begin
					a_v = 1'b1;
					a_tok = mk_tok(KIND_UNTERM, tl_q, tc_q, len_q);
					b_v = 1'b1;
					b_tok = mk_tok(KIND_END, line_n, col_n, '0);
					mode_n = MODE_IDLE;
				end else begin
					len_n = len_inc;
				end
			end
			MODE_TAG: begin
				if (c_word) begin
					len_n = len_inc;
				end else begin
					a_v = 1'b1;
					a_tok = mk_tok(KIND_TAG, tl_q, tc_q, len_q);
					mode_n = MODE_IDLE;
					idle_pass = 1'b1;
				end
			end
			MODE_WORD: begin
				if (c_word) begin
					len_n = len_inc;
					if (!c_dig) num_n = 1'b0;
				end else begin
					a_v = 1'b1;
					a_tok = mk_tok(((len_q == LENGTH_BITS'(1)) ? fd_q : num_q) ?
						KIND_INTEGER : KIND_SYMBOL, tl_q, tc_q, len_q);
					mode_n = MODE_IDLE;
					idle_pass = 1'b1;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
				idle_pass = 1'b1;
			end
		endcase

		if (idle_pass && !c_ws) begin
			if (char_in == CH_NUL) begin
				b_v = 1'b1;
				b_tok = mk_tok(KIND_END, line_n, col_n, '0);
			end else if (char_in == CH_SEMI) begin
				tl_n = line_n;
				tc_n = col_n;
				len_n = '0;
				mode_n = MODE_COMMENT;
			end else if (char_in == CH_APOS) begin
				b_v = 1'b1;
				b_tok = mk_tok(KIND_QUOTE, line_n, col_n, LENGTH_BITS'(1));
			end else if (char_in == CH_LPAR) begin
				b_v = 1'b1;
				b_tok = mk_tok(KIND_OPEN, line_n, col_n, LENGTH_BITS'(1));
			end else if (char_in == CH_RPAR) begin
				b_v = 1'b1;
				b_tok = mk_tok(KIND_CLOSE, line_n, col_n, LENGTH_BITS'(1));
			end else begin
				tl_n = line_n;
				tc_n = col_n;
				len_n = LENGTH_BITS'(1);
				if (char_in == CH_DQUOTE) begin
					mode_n = MODE_STRING;
				end else if (char_in == CH_HASH) begin
					mode_n = MODE_TAG;
				end else begin
					fd_n = c_dig;
					num_n = c_dig || (char_in == CH_PLUS) || (char_in == CH_MINUS);
					mode_n = MODE_WORD;
				end
			end
		end
	end

	// pair layout: {has_second, second, first}
	assign wr_en   = accept && (a_v || b_v);
	assign wr_data = a_v ? {b_v, b_tok, a_tok} : {1'b0, {TOK_W{1'b0}}, b_tok};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			line_q <= LINE_BITS'(1);
			col_q  <= '1;
			pre_q  <= 1'b1;
			tl_q   <= LINE_BITS'(1);
			tc_q   <= '0;
			len_q  <= '0;
			num_q  <= 1'b0;
			fd_q   <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_n;
			line_q <= line_n;
			col_q  <= col_n;
			pre_q  <= pre_n;
			tl_q   <= tl_n;
			tc_q   <= tc_n;
			len_q  <= len_n;
			num_q  <= num_n;
			fd_q   <= fd_n;
		end
	end

endmodule

@@ hw/rtl/sxt_queue.sv @@
// Short queue of token pairs between front and back end.
module sxt_queue import sxt_pkg::*; #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output sxt_qstat_t       stat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_wr, do_rd;

	assign stat.not_empty = (cnt_q != '0);
	assign stat.full      = (cnt_q == (PTR_W + 1)'(QUEUE_DEPTH));
	assign do_wr   = wr_en && !stat.full;
	assign do_rd   = rd_en && stat.not_empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= wp_q + PTR_W'(1);
			if (do_rd) rp_q <= rp_q + PTR_W'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + (PTR_W + 1)'(1);
			else if (do_rd && !do_wr) cnt_q <= cnt_q - (PTR_W + 1)'(1);
		end
	end

endmodule

@@ hw/rtl/sxt_back.sv @@
// Back end: output register that hands out the tokens of each pair one by one.
module sxt_back import sxt_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int LENGTH_BITS = 8,
	parameter int TOK_W       = KIND_W + 2 * LINE_BITS + LENGTH_BITS,
	parameter int PAIR_W      = 2 * TOK_W + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [PAIR_W-1:0]      head,
	input  sxt_qstat_t             qstat,
	output logic                   q_pop,
	input  logic                   pop,
	output logic                   empty,
	output logic [KIND_W-1:0]      token_kind,
	output logic [LINE_BITS-1:0]   start_line,
	output logic [LINE_BITS-1:0]   start_column,
	output logic [LENGTH_BITS-1:0] token_length,
	output logic                   last_of_run
);

	logic [PAIR_W-1:0] ent_q;
	logic              valid_q, sel_q;
	logic              taken, has2, step_second, done;
	logic [TOK_W-1:0]  tok;

	assign has2        = ent_q[PAIR_W-1];
	assign taken       = valid_q && pop;
	assign step_second = taken && !sel_q && has2;
	assign done        = !valid_q || (taken && !step_second);
	assign q_pop       = done && qstat.not_empty;

	assign tok          = sel_q ? ent_q[2*TOK_W-1:TOK_W] : ent_q[TOK_W-1:0];
	assign empty        = !valid_q;
	assign token_kind   = tok[TOK_W-1 -: KIND_W];
	assign start_line   = tok[2*LINE_BITS+LENGTH_BITS-1 -: LINE_BITS];
	assign start_column = tok[LINE_BITS+LENGTH_BITS-1 -: LINE_BITS];
	assign token_length = tok[LENGTH_BITS-1:0];
	assign last_of_run  = sel_q || !has2;

	always_ff @(posedge clk) begin
		if (q_pop) ent_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else if (step_second) begin
			sel_q <= 1'b1;
		end else if (done) begin
			valid_q <= qstat.not_empty;
			sel_q   <= 1'b0;
		end
	end

endmodule

@@ hw/rtl/sexpr_tokenizer_unit.sv @@
// A byte's tokens pass through the pair queue and then the output register.
// Throughput: one byte per cycle while full is low; two-token bytes need two pops.
// Front end scans combinationally; a four-pair queue and the output register decouple.
// full rises only when the pair queue holds four pending pairs.
// arst_n low clears scan state, queue, output; first byte is at line 1, column 0.
`include "sexpr_tokenizer_unit_macros.svh"

module sexpr_tokenizer_unit import sxt_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int LENGTH_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             char_in,
	output logic                   empty,
	input  logic                   pop,
	output logic [KIND_W-1:0]      token_kind,
	output logic [LINE_BITS-1:0]   start_line,
	output logic [LINE_BITS-1:0]   start_column,
	output logic [LENGTH_BITS-1:0] token_length,
	output logic                   last_of_run
);

	localparam int TOK_W  = KIND_W + 2 * LINE_BITS + LENGTH_BITS;
	localparam int PAIR_W = 2 * TOK_W + 1;

	logic              accept, wr_en, q_pop;
	logic [PAIR_W-1:0] wr_data, head;
	sxt_qstat_t        qstat;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	sxt_front #(
		.LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS), .TOK_W(TOK_W), .PAIR_W(PAIR_W)
	) u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .char_in(char_in),
		.wr_en(wr_en), .wr_data(wr_data)
	);

	sxt_queue #(.WIDTH(PAIR_W)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(wr_data),
		.rd_en(q_pop), .rd_data(head), .stat(qstat)
	);

	sxt_back #(
		.LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS), .TOK_W(TOK_W), .PAIR_W(PAIR_W)
	) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .qstat(qstat), .q_pop(q_pop),
		.pop(pop), .empty(empty), .token_kind(token_kind), .start_line(start_line),
		.start_column(start_column), .token_length(token_length),
		.last_of_run(last_of_run)
	);

	`SXT_ASSERT_NOW(a_kind_range, clk, arst_n, !empty, token_kind <= KIND_UNTERM)
	`SXT_ASSERT_NOW(a_end_len, clk, arst_n, !empty && token_kind == KIND_END, token_length == '0)
	`SXT_ASSERT_NOW(a_line_nonzero, clk, arst_n, !empty, start_line != '0)
	`SXT_ASSERT_NEXT(a_second_follows, clk, arst_n, !empty && pop && !last_of_run, !empty)

endmodule
